>>> rtl/mstep_pkg.sv
// ----------------------------------------------------------------------------
// mstep_pkg
// Shared types and constants for the multi-stepper step generator: beat
// payloads, register indexes, flag bit positions and controller commands.
// ----------------------------------------------------------------------------
package mstep_pkg;

    localparam int SLOT_W     = 3;
    localparam int TARGET_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 4;

    localparam int MICROSTEPS_PER_STEP = 8;
    localparam int MS_SHIFT            = 3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_STEPPERS_IN_USE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL           = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_AFTER     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_FRAMES     = 8'd3;

    localparam logic [COUNT_W-1:0]    RST_STEPPERS_IN_USE = 4'd1;
    localparam logic [7:0]            RST_DECEL           = 8'd0;
    localparam logic [31:0]           RST_SLEEP_AFTER     = 32'd1000000;
    localparam logic [15:0]           RST_WAKE_FRAMES     = 16'd100;

    // per-slot flag bits
    localparam int FLAG_W  = 6;
    localparam int F_HIGH  = 0;
    localparam int F_AWAKE = 1;
    localparam int F_MOVE  = 2;
    localparam int F_DIR   = 3;
    localparam int F_MS1   = 4;
    localparam int F_MS2   = 5;

    typedef struct packed {
        logic                command;
        logic [SLOT_W-1:0]   stepper_index;
        logic [TARGET_W-1:0] requested_steps;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              latch_written;
        logic              direction;
        logic              step_level;
        logic              ms1;
        logic              ms2;
        logic              awake;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              tick;
        logic              set_target;
        logic              load;
        logic              pick;
        logic              commit;
        logic              last;
        logic [SLOT_W-1:0] slot;
    } dp_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
    } dp_status_t;

endpackage

>>> rtl/mstep_ctrl.sv
// ----------------------------------------------------------------------------
// mstep_ctrl
// Sequencer: accepts items, walks the serviced slots through load, pick and
// commit, and owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module mstep_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic                   item_command,
    output logic                   result_valid,
    input  logic                   result_stall,
    output mstep_pkg::dp_cmd_t     cmd,
    input  mstep_pkg::dp_status_t  status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOAD   = 2'd1;
    localparam logic [1:0] S_PICK   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [mstep_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                         res_valid_reg, res_valid_next;
    logic                         accept;
    logic                         out_free;
    logic                         is_last;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign is_last      = ({1'b0, slot_reg} == (status.count - 4'd1));

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        res_valid_next = res_valid_reg && result_stall;
        cmd            = '0;
        cmd.slot       = slot_reg;
        cmd.last       = is_last;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item_command == mstep_pkg::CMD_SET)
                    begin
                        cmd.set_target = 1'b1;
                    end
                    else
                    begin
                        cmd.tick  = 1'b1;
                        slot_next = '0;
                        if (status.count != '0)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    res_valid_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 3'd1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

>>> rtl/mstep_datapath.sv
// ----------------------------------------------------------------------------
// mstep_datapath
// Configuration registers, frame counter, per-slot state and the three-phase
// slot evaluation (tests, step size, commit) feeding the result register.
// ----------------------------------------------------------------------------
module mstep_datapath #(
    parameter int NUM_STEPPERS  = 8,
    parameter int FRAME_BITS    = 48,
    parameter int POSITION_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [mstep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mstep_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  mstep_pkg::item_t                    item,
    input  mstep_pkg::dp_cmd_t                  cmd,
    output mstep_pkg::dp_status_t               status,
    output mstep_pkg::result_t                  result
);

    localparam int IDX_W = (NUM_STEPPERS > 1) ? $clog2(NUM_STEPPERS) : 1;
    localparam int FB    = FRAME_BITS;
    localparam int PB    = POSITION_BITS;
    localparam int TH_W  = 14;
    localparam int CW    = (PB > TH_W) ? PB : TH_W;
    localparam int TS_W  = mstep_pkg::TARGET_W + mstep_pkg::MS_SHIFT;

    // configuration
    logic [mstep_pkg::COUNT_W-1:0] steppers_reg;
    logic [7:0]                    decel_reg;
    logic [31:0]                   sleep_reg;
    logic [15:0]                   wake_reg;

    // block state
    logic [FB-1:0]                      frame_reg;
    logic [PB-1:0]                      pos_reg       [NUM_STEPPERS];
    logic [PB-1:0]                      des_reg       [NUM_STEPPERS];
    logic [mstep_pkg::TARGET_W-1:0]     tgt_reg       [NUM_STEPPERS];
    logic [FB-1:0]                      awake_aft_reg [NUM_STEPPERS];
    logic [FB-1:0]                      last_upd_reg  [NUM_STEPPERS];
    logic [mstep_pkg::FLAG_W-1:0]       flags_reg     [NUM_STEPPERS];

    // phase A
    logic [mstep_pkg::FLAG_W-1:0] a_flags_reg;
    logic [PB-1:0]                a_pos_reg;
    logic [PB-1:0]                a_des_reg;
    logic                         a_rest_reg;
    logic                         a_waking_reg;
    logic                         a_idle_reg;
    logic [FB-1:0]                a_wake_until_reg;

    // phase B
    logic                         b_lt_reg;
    logic                         b_gt_reg;
    logic                         b_ms1_reg;
    logic                         b_ms2_reg;

    mstep_pkg::result_t           result_reg;

    logic [IDX_W-1:0]             idx;
    logic [IDX_W-1:0]             set_idx;
    logic                         set_ok;

    logic [mstep_pkg::FLAG_W-1:0] s_flags;
    logic [PB-1:0]                s_pos;
    logic [FB-1:0]                idle_diff;
    logic [TS_W-1:0]              tgt_scaled;
    logic [PB-1:0]                des_eff;

    logic [PB-1:0]                togo;
    logic [CW-1:0]                togo_w;
    logic [CW-1:0]                th8;
    logic [CW-1:0]                th4;
    logic [CW-1:0]                th2;
    logic                         pick_ms1;
    logic                         pick_ms2;

    logic [mstep_pkg::FLAG_W-1:0] c_flags;
    logic                         c_wr;
    logic                         c_wake;
    logic                         c_des_wr;
    logic                         c_pos_wr;
    logic [PB-1:0]                c_pos;
    logic [PB-1:0]                c_step;

    assign idx     = cmd.slot[IDX_W-1:0];
    assign set_idx = item.stepper_index[IDX_W-1:0];
    assign set_ok  = (4'(item.stepper_index) < 4'(NUM_STEPPERS));

    assign status.count = (steppers_reg > 4'(NUM_STEPPERS)) ? 4'(NUM_STEPPERS)
                                                            : steppers_reg;
    assign result       = result_reg;

    // phase A: rule tests and boundary reload
    always_comb
    begin
        s_flags    = flags_reg[idx];
        s_pos      = pos_reg[idx];
        idle_diff  = frame_reg - last_upd_reg[idx];
        tgt_scaled = {tgt_reg[idx], {mstep_pkg::MS_SHIFT{1'b0}}};
        if (s_pos[mstep_pkg::MS_SHIFT-1:0] == '0)
        begin
            des_eff = PB'(tgt_scaled);
        end
        else
        begin
            des_eff = des_reg[idx];
        end
    end

    // phase B: direction and step size
    always_comb
    begin
        if (a_pos_reg > a_des_reg)
        begin
            togo = a_pos_reg - a_des_reg;
        end
        else
        begin
            togo = a_des_reg - a_pos_reg;
        end
        togo_w = CW'(togo);
        th8    = CW'({decel_reg, 6'b0});
        th4    = CW'({decel_reg, 5'b0});
        th2    = CW'({decel_reg, 4'b0});
        if (decel_reg == '0 || togo_w > th8)
        begin
            pick_ms1 = 1'b0;
            pick_ms2 = 1'b0;
        end
        else if (togo_w > th4)
        begin
            pick_ms1 = 1'b1;
            pick_ms2 = 1'b0;
        end
        else if (togo_w > th2)
        begin
            pick_ms1 = 1'b0;
            pick_ms2 = 1'b1;
        end
        else
        begin
            pick_ms1 = 1'b1;
            pick_ms2 = 1'b1;
        end
    end

    // commit: rules in priority order
    always_comb
    begin
        c_flags  = a_flags_reg;
        c_wr     = 1'b1;
        c_wake   = 1'b0;
        c_des_wr = 1'b0;
        c_pos_wr = 1'b0;
        case ({b_ms2_reg, b_ms1_reg})
            2'b00:   c_step = PB'(8);
            2'b01:   c_step = PB'(4);
            2'b10:   c_step = PB'(2);
            default: c_step = PB'(1);
        endcase
        c_pos = b_gt_reg ? (a_pos_reg - c_step) : (a_pos_reg + c_step);
        if (a_flags_reg[mstep_pkg::F_HIGH])
        begin
            c_flags[mstep_pkg::F_HIGH] = 1'b0;
        end
        else if (a_waking_reg)
        begin
            c_wr = 1'b0;
        end
        else if (a_idle_reg)
        begin
            c_flags[mstep_pkg::F_AWAKE] = 1'b0;
        end
        else if (a_rest_reg)
        begin
            c_wr = 1'b0;
        end
        else if (!a_flags_reg[mstep_pkg::F_AWAKE])
        begin
            c_flags[mstep_pkg::F_AWAKE] = 1'b1;
            c_wake                      = 1'b1;
        end
        else
        begin
            c_des_wr = 1'b1;
            if (b_lt_reg || b_gt_reg)
            begin
                c_pos_wr                   = 1'b1;
                c_flags[mstep_pkg::F_MS1]  = b_ms1_reg;
                c_flags[mstep_pkg::F_MS2]  = b_ms2_reg;
                c_flags[mstep_pkg::F_DIR]  = b_gt_reg;
                c_flags[mstep_pkg::F_HIGH] = 1'b1;
            end
        end
        if (c_wr)
        begin
            c_flags[mstep_pkg::F_MOVE] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steppers_reg <= mstep_pkg::RST_STEPPERS_IN_USE;
            decel_reg    <= mstep_pkg::RST_DECEL;
            sleep_reg    <= mstep_pkg::RST_SLEEP_AFTER;
            wake_reg     <= mstep_pkg::RST_WAKE_FRAMES;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mstep_pkg::REG_STEPPERS_IN_USE: steppers_reg <= cfg_data[3:0];
                mstep_pkg::REG_DECEL:           decel_reg    <= cfg_data[7:0];
                mstep_pkg::REG_SLEEP_AFTER:     sleep_reg    <= cfg_data;
                mstep_pkg::REG_WAKE_FRAMES:     wake_reg     <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            for (int i = 0; i < NUM_STEPPERS; i++)
            begin
                pos_reg[i]       <= '0;
                des_reg[i]       <= '0;
                tgt_reg[i]       <= '0;
                awake_aft_reg[i] <= '0;
                last_upd_reg[i]  <= '0;
                flags_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cmd.tick)
            begin
                frame_reg <= frame_reg + FB'(1);
            end
            if (cmd.set_target && set_ok)
            begin
                tgt_reg[set_idx]                     <= item.requested_steps;
                flags_reg[set_idx][mstep_pkg::F_MOVE] <= 1'b1;
            end
            if (cmd.commit)
            begin
                flags_reg[idx] <= c_flags;
                if (c_wr)
                begin
                    last_upd_reg[idx] <= frame_reg;
                end
                if (c_wake)
                begin
                    awake_aft_reg[idx] <= a_wake_until_reg;
                end
                if (c_des_wr)
                begin
                    des_reg[idx] <= a_des_reg;
                end
                if (c_pos_wr)
                begin
                    pos_reg[idx] <= c_pos;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_flags_reg      <= s_flags;
            a_pos_reg        <= s_pos;
            a_des_reg        <= des_eff;
            a_rest_reg       <= (s_pos == des_reg[idx]) && !s_flags[mstep_pkg::F_MOVE];
            a_waking_reg     <= (awake_aft_reg[idx] > frame_reg);
            a_idle_reg       <= s_flags[mstep_pkg::F_AWAKE]
                                && (frame_reg > last_upd_reg[idx])
                                && (idle_diff > FB'(sleep_reg));
            a_wake_until_reg <= frame_reg + FB'(wake_reg);
        end
        if (cmd.pick)
        begin
            b_lt_reg  <= (a_pos_reg < a_des_reg);
            b_gt_reg  <= (a_pos_reg > a_des_reg);
            b_ms1_reg <= pick_ms1;
            b_ms2_reg <= pick_ms2;
        end
        if (cmd.commit)
        begin
            result_reg.slot          <= cmd.slot;
            result_reg.latch_written <= c_wr;
            result_reg.direction     <= c_flags[mstep_pkg::F_DIR];
            result_reg.step_level    <= c_flags[mstep_pkg::F_HIGH];
            result_reg.ms1           <= c_flags[mstep_pkg::F_MS1];
            result_reg.ms2           <= c_flags[mstep_pkg::F_MS2];
            result_reg.awake         <= c_flags[mstep_pkg::F_AWAKE];
            result_reg.last          <= cmd.last;
        end
    end

endmodule

>>> rtl/multi_stepper_step_generator_core.sv
// ----------------------------------------------------------------------------
// multi_stepper_step_generator_core
// Step, direction, microstep and sleep generation for up to eight stepper
// drivers sharing one latch bus.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_stall, item): a set-target beat stores one
//   slot's target and raises its move request; it gives no result. A tick
//   beat advances the frame counter and services slots 0 .. N-1 in order,
//   with N = min(steppers_in_use, NUM_STEPPERS) and one result beat per slot.
//   result channel (result_valid/result_stall, result): one beat per serviced
//   slot, the final one of a tick flagged by last.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while the block is idle.
// Flow: each slot passes through load, pick and commit on one shared
//   evaluation unit, and the commit writes the result register. A stalled
//   result holds in the output register and only the commit of the next
//   slot waits; the final result may stay pending while the next item is
//   taken.
// Reset: all slot state, frame counter and flags clear; registers take their
//   documented defaults.
// ----------------------------------------------------------------------------
module multi_stepper_step_generator_core #(
    parameter int NUM_STEPPERS  = 8,
    parameter int FRAME_BITS    = 48,
    parameter int POSITION_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  mstep_pkg::item_t                 item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mstep_pkg::result_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mstep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mstep_pkg::CFG_DATA_W-1:0] cfg_data
);

    mstep_pkg::dp_cmd_t    cmd;
    mstep_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mstep_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_command (item.command),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    mstep_datapath #(
        .NUM_STEPPERS  (NUM_STEPPERS),
        .FRAME_BITS    (FRAME_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

>>> sim/multi_stepper_step_generator_core_tb.sv
// ----------------------------------------------------------------------------
// multi_stepper_step_generator_core_tb
// Self-checking bench for the step generator core. Set-target and tick beats
// are fed from a backlog queue, and a behavioural copy of the slot rules
// predicts every latch beat. Result beats are checked field by field in
// order. Runs go through several register settings, random sender gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module multi_stepper_step_generator_core_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int SLOTS        = 8;
    localparam int SETTLE       = 12;
    localparam int HOLD_LEN     = 300;
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 30;

    localparam logic [mstep_pkg::CFG_IDX_W-1:0] REG_NONE = 8'd4;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    mstep_pkg::item_t   item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    mstep_pkg::result_t result;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [mstep_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mstep_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // bench control; idle_pct, stall_pct and hold_go are written on the falling edge
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_go   = 1'b0;
    int   hold_left = 0;
    int   mismatches = 0;

    mstep_pkg::item_t   cmd_backlog[$];
    mstep_pkg::result_t latch_beats_due[$];

    // register mirror
    logic [3:0]  cfg_count = mstep_pkg::RST_STEPPERS_IN_USE;
    logic [7:0]  cfg_decel = mstep_pkg::RST_DECEL;
    logic [31:0] cfg_sleep = mstep_pkg::RST_SLEEP_AFTER;
    logic [15:0] cfg_wake  = mstep_pkg::RST_WAKE_FRAMES;

    // slot state mirror
    logic [47:0]                 frame = '0;
    logic [19:0]                 pos_ms     [SLOTS] = '{default: '0};
    logic [19:0]                 want_ms    [SLOTS] = '{default: '0};
    logic [15:0]                 tgt_steps  [SLOTS] = '{default: '0};
    logic [47:0]                 wake_until [SLOTS] = '{default: '0};
    logic [47:0]                 last_write [SLOTS] = '{default: '0};
    logic [mstep_pkg::FLAG_W-1:0] flags      [SLOTS] = '{default: '0};

    multi_stepper_step_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("multi_stepper_step_generator_core: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s got %0h, want %0h", $time, what, got, want);
    endtask

    // microstep size for the remaining distance; sets ms1/ms2
    function automatic logic [3:0] pick_size(input int s);
        logic [19:0] togo;
        logic [31:0] gap;
        logic [31:0] scale;
        togo  = (pos_ms[s] > want_ms[s]) ? pos_ms[s] - want_ms[s] : want_ms[s] - pos_ms[s];
        gap   = {12'd0, togo};
        scale = {24'd0, cfg_decel} << 3;
        flags[s][mstep_pkg::F_MS1] = 1'b0;
        flags[s][mstep_pkg::F_MS2] = 1'b0;
        if (cfg_decel == 8'd0 || gap > scale * 8)
            return 4'd8;
        if (gap > scale * 4)
        begin
            flags[s][mstep_pkg::F_MS1] = 1'b1;
            return 4'd4;
        end
        if (gap > scale * 2)
        begin
            flags[s][mstep_pkg::F_MS2] = 1'b1;
            return 4'd2;
        end
        flags[s][mstep_pkg::F_MS1] = 1'b1;
        flags[s][mstep_pkg::F_MS2] = 1'b1;
        return 4'd1;
    endfunction

    // slot rules in priority order; returns 1 when the latch is written
    function automatic logic service_slot(input int s);
        logic [mstep_pkg::FLAG_W-1:0] f;
        logic [3:0]                   n;
        f = flags[s];
        if (f[mstep_pkg::F_HIGH])
        begin
            flags[s][mstep_pkg::F_HIGH] = 1'b0;
            return 1'b1;
        end
        if (wake_until[s] > frame)
            return 1'b0;
        if (f[mstep_pkg::F_AWAKE] && frame > last_write[s] &&
            (frame - last_write[s]) > {16'd0, cfg_sleep})
        begin
            flags[s][mstep_pkg::F_AWAKE] = 1'b0;
            return 1'b1;
        end
        if (pos_ms[s] == want_ms[s] && !f[mstep_pkg::F_MOVE])
            return 1'b0;
        if (!f[mstep_pkg::F_AWAKE])
        begin
            flags[s][mstep_pkg::F_AWAKE] = 1'b1;
            wake_until[s] = frame + {32'd0, cfg_wake};
            return 1'b1;
        end
        if (pos_ms[s][2:0] == 3'd0)
            want_ms[s] = {1'b0, tgt_steps[s], 3'b000};
        if (pos_ms[s] < want_ms[s])
        begin
            n = pick_size(s);
            flags[s][mstep_pkg::F_DIR]  = 1'b0;
            flags[s][mstep_pkg::F_HIGH] = 1'b1;
            pos_ms[s] = pos_ms[s] + n;
        end
        else if (pos_ms[s] > want_ms[s])
        begin
            n = pick_size(s);
            flags[s][mstep_pkg::F_DIR]  = 1'b1;
            flags[s][mstep_pkg::F_HIGH] = 1'b1;
            pos_ms[s] = pos_ms[s] - n;
        end
        return 1'b1;
    endfunction

    function automatic void advance_frame();
        int                 n;
        logic               wr;
        mstep_pkg::result_t r;
        frame = frame + 48'd1;
        n = (cfg_count > 4'd8) ? SLOTS : int'(cfg_count);
        for (int i = 0; i < n; i++)
        begin
            wr = service_slot(i);
            if (wr)
            begin
                flags[i][mstep_pkg::F_MOVE] = 1'b0;
                last_write[i] = frame;
            end
            r.slot          = 3'(i);
            r.latch_written = wr;
            r.direction     = flags[i][mstep_pkg::F_DIR];
            r.step_level    = flags[i][mstep_pkg::F_HIGH];
            r.ms1           = flags[i][mstep_pkg::F_MS1];
            r.ms2           = flags[i][mstep_pkg::F_MS2];
            r.awake         = flags[i][mstep_pkg::F_AWAKE];
            r.last          = (i == n - 1);
            latch_beats_due.push_back(r);
        end
    endfunction

    function automatic mstep_pkg::item_t random_command();
        mstep_pkg::item_t it;
        it.command         = ($urandom_range(99) < 30) ? mstep_pkg::CMD_SET
                                                       : mstep_pkg::CMD_TICK;
        it.stepper_index   = 3'($urandom_range(7));
        it.requested_steps = ($urandom_range(99) < 20) ? 16'($urandom_range(16'hFFFF))
                                                       : 16'($urandom_range(12));
        return it;
    endfunction

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        logic fire;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            fire = item_valid && !item_stall;
            if (fire)
            begin
                if (item.command == mstep_pkg::CMD_SET)
                begin
                    tgt_steps[item.stepper_index]                = item.requested_steps;
                    flags[item.stepper_index][mstep_pkg::F_MOVE] = 1'b1;
                end
                else
                    advance_frame();
            end
            if (!item_valid || fire)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= cmd_backlog.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall generation
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        mstep_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (latch_beats_due.size() == 0)
                    report_mismatch("result beat with nothing expected", result, 0);
                else
                begin
                    want = latch_beats_due.pop_front();
                    if (result.slot !== want.slot)
                        report_mismatch("slot", result.slot, want.slot);
                    if (result.latch_written !== want.latch_written)
                        report_mismatch("latch_written", result.latch_written,
                                        want.latch_written);
                    if (result.direction !== want.direction)
                        report_mismatch("direction", result.direction, want.direction);
                    if (result.step_level !== want.step_level)
                        report_mismatch("step_level", result.step_level, want.step_level);
                    if (result.ms1 !== want.ms1)
                        report_mismatch("ms1", result.ms1, want.ms1);
                    if (result.ms2 !== want.ms2)
                        report_mismatch("ms2", result.ms2, want.ms2);
                    if (result.awake !== want.awake)
                        report_mismatch("awake", result.awake, want.awake);
                    if (result.last !== want.last)
                        report_mismatch("last", result.last, want.last);
                end
            end
            if (hold_go)
            begin
                hold_left    <= HOLD_LEN;
                result_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [mstep_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mstep_pkg::REG_STEPPERS_IN_USE: cfg_count = val[3:0];
            mstep_pkg::REG_DECEL:           cfg_decel = val[7:0];
            mstep_pkg::REG_SLEEP_AFTER:     cfg_sleep = val;
            mstep_pkg::REG_WAKE_FRAMES:     cfg_wake  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [3:0] count, input logic [7:0] decel,
                            input logic [31:0] sleep_frames, input logic [15:0] wake);
        write_reg(mstep_pkg::REG_STEPPERS_IN_USE, {28'd0, count});
        write_reg(mstep_pkg::REG_DECEL, {24'd0, decel});
        write_reg(mstep_pkg::REG_SLEEP_AFTER, sleep_frames);
        write_reg(mstep_pkg::REG_WAKE_FRAMES, {16'd0, wake});
    endtask

    // waits until the backlog is sent and every predicted beat has arrived
    task automatic drain();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || item_valid || latch_beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_random(input int n, input int idle, input int stall);
        @(negedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) cmd_backlog.push_back(random_command());
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: one slot serviced, nothing moving
        @(negedge clk);
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_TICK, 3'd0, 16'd0});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_SET,  3'd5, 16'd9});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_TICK, 3'd7, 16'hFFFF});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_TICK, 3'd0, 16'd0});
        drain();

        // directed: extreme targets, hold with move request, idle sleep
        set_regs(4'd8, 8'd0, 32'd4, 16'd0);
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        @(negedge clk);
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_SET, 3'd0, 16'hFFFF});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_SET, 3'd1, 16'd1});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_SET, 3'd3, 16'd2});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_SET, 3'd7, 16'd0});
        repeat (8)
            cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_TICK, 3'd0, 16'd0});
        cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_SET, 3'd7, 16'd0});
        repeat (6)
            cmd_backlog.push_back(mstep_pkg::item_t'{mstep_pkg::CMD_TICK, 3'd0, 16'd0});
        drain();

        set_regs(4'd8, 8'd0, 32'd20, 16'd0);
        run_random(40, 0, 0);

        set_regs(4'd4, 8'd2, 32'd6, 16'd2);
        run_random(45, 74, 0);

        set_regs(4'd8, 8'd1, 32'd0, 16'd1);
        run_random(45, 0, 74);

        set_regs(4'd15, 8'd255, 32'd10, 16'd3);
        run_random(45, 36, 36);

        // long receiver hold-off with the sender pushing on
        set_regs(4'd8, 8'd0, 32'd50, 16'd0);
        @(negedge clk);
        idle_pct  = 0;
        stall_pct = 0;
        repeat (40) cmd_backlog.push_back(random_command());
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
        drain();

        // no slot in use: ticks give no beats
        write_reg(mstep_pkg::REG_STEPPERS_IN_USE, 32'd0);
        run_random(6, 0, 0);

        write_reg(mstep_pkg::REG_STEPPERS_IN_USE, 32'd1);
        run_random(15, 36, 36);

        set_regs(4'd8, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
        run_random(25, 36, 36);

        if (latch_beats_due.size() != 0)
            report_mismatch("results never delivered", latch_beats_due.size(), 0);
        if (mismatches == 0)
            $display("multi_stepper_step_generator_core: match");
        else
            $display("multi_stepper_step_generator_core: mismatch");
        $finish;
    end

endmodule
